/* design/b64d_pkg.sv */
// b64d_pkg: shared types, constants and the character decode for the base64 stream decoder
// depends on nothing; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  localparam int COUNT_WIDTH_DEF  = 24;
  localparam int QUEUE_DEPTH_DEF  = 4;
  localparam int MAX_LEN_W        = 24;
  localparam int GROUP_W          = 24;
  localparam logic [MAX_LEN_W-1:0] MAX_LENGTH_RST = MAX_LEN_W'(12 << 20);

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHAR_D0    = 8'h30;
  localparam logic [7:0] CHAR_D9    = 8'h39;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_PADDING  = 3'd2,
    ST_LENGTH   = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  // one unit of work for the back end: an error result or a decoded quad
  typedef struct packed {
    logic                is_err;
    status_t             status;
    logic [GROUP_W-1:0]  group;
    logic [1:0]          nbytes;
    logic                last;
  } job_t;

  // returns {valid, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c inside {[CHAR_UP_A:CHAR_UP_Z]}) begin
        v = c - CHAR_UP_A;
        sextet_of = {1'b1, v[5:0]};
      end else if (c inside {[CHAR_LO_A:CHAR_LO_Z]}) begin
        v = c - CHAR_LO_A + 8'd26;
        sextet_of = {1'b1, v[5:0]};
      end else if (c inside {[CHAR_D0:CHAR_D9]}) begin
        v = c - CHAR_D0 + 8'd52;
        sextet_of = {1'b1, v[5:0]};
      end else if (c == CHAR_PLUS) begin
        sextet_of = {1'b1, 6'd62};
      end else if (c == CHAR_SLASH) begin
        sextet_of = {1'b1, 6'd63};
      end else begin
        sextet_of = {1'b0, 6'd0};
      end
    end
  endfunction

endpackage

`default_nettype wire

/* design/b64d_front.sv */
// b64d_front: accepts characters, tracks the quad and stream state, classifies errors
// depends on b64d_pkg; pushes jobs into b64d_queue
`timescale 1ns / 1ps
`default_nettype none

module b64d_front #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_accept,
  input  wire logic [7:0]                     in_code_char,
  input  wire logic                           in_stream_last,
  input  wire logic [b64d_pkg::MAX_LEN_W-1:0] max_length,
  output logic                                job_push,
  output b64d_pkg::job_t                      job
);

  localparam int CmpW = (COUNT_WIDTH + 1 > b64d_pkg::MAX_LEN_W) ?
                        COUNT_WIDTH + 1 : b64d_pkg::MAX_LEN_W;

  logic [b64d_pkg::GROUP_W-1:0] group_r, group_nxt;
  logic [1:0]                   qpos_r, qpos_nxt;
  logic [1:0]                   pad_r, pad_nxt;
  logic [COUNT_WIDTH-1:0]       count_r, count_nxt;
  logic                         disc_r, disc_nxt;

  logic [6:0] sx;
  logic       is_pad;
  logic       too_long;

  assign sx       = b64d_pkg::sextet_of(in_code_char);
  assign is_pad   = (in_code_char == b64d_pkg::CHAR_PAD);
  assign too_long = (&count_r) ||
                    ((CmpW'(count_r) + CmpW'(1)) > CmpW'(max_length));

  always_comb begin
    logic                         err;
    b64d_pkg::status_t            st;
    logic [b64d_pkg::GROUP_W-1:0] grp_new;
    logic [1:0]                   pad_new;

    err       = 1'b0;
    st        = b64d_pkg::ST_OK;
    grp_new   = group_r;
    pad_new   = pad_r;
    group_nxt = group_r;
    qpos_nxt  = qpos_r;
    pad_nxt   = pad_r;
    count_nxt = count_r;
    disc_nxt  = disc_r;
    job_push  = 1'b0;
    job       = '0;

    if (in_accept) begin
      if (disc_r) begin
        if (in_stream_last) begin
          disc_nxt = 1'b0;
        end
      end else if (too_long) begin
        err = 1'b1;
        st  = b64d_pkg::ST_TOO_LONG;
      end else begin
        count_nxt = count_r + COUNT_WIDTH'(1);
        if (is_pad) begin
          if (qpos_r < 2'd2) begin
            err = 1'b1;
            st  = b64d_pkg::ST_PADDING;
          end else begin
            pad_new = pad_r + 2'd1;
            grp_new = {group_r[b64d_pkg::GROUP_W-7:0], 6'd0};
          end
        end else if (pad_r != 2'd0) begin
          err = 1'b1;
          st  = b64d_pkg::ST_PADDING;
        end else if (!sx[6]) begin
          err = 1'b1;
          st  = b64d_pkg::ST_INVALID;
        end else begin
          grp_new = {group_r[b64d_pkg::GROUP_W-7:0], sx[5:0]};
        end

        if (!err) begin
          if (qpos_r != 2'd3) begin
            group_nxt = grp_new;
            pad_nxt   = pad_new;
            qpos_nxt  = qpos_r + 2'd1;
            if (in_stream_last) begin
              err = 1'b1;
              st  = b64d_pkg::ST_LENGTH;
            end
          end else if (pad_new != 2'd0 && !in_stream_last) begin
            err = 1'b1;
            st  = b64d_pkg::ST_PADDING;
          end else begin
            // quad complete: hand the group to the back end
            job_push   = 1'b1;
            job.group  = grp_new;
            job.nbytes = 2'd3 - pad_new;
            job.last   = in_stream_last;
            group_nxt  = '0;
            qpos_nxt   = 2'd0;
            pad_nxt    = 2'd0;
            if (in_stream_last) begin
              count_nxt = '0;
            end
          end
        end
      end

      if (err) begin
        group_nxt  = '0;
        qpos_nxt   = 2'd0;
        pad_nxt    = 2'd0;
        count_nxt  = '0;
        disc_nxt   = !in_stream_last;
        job_push   = 1'b1;
        job.is_err = 1'b1;
        job.status = st;
        job.nbytes = 2'd1;
        job.last   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= '0;
      qpos_r  <= 2'd0;
      pad_r   <= 2'd0;
      count_r <= '0;
      disc_r  <= 1'b0;
    end else begin
      group_r <= group_nxt;
      qpos_r  <= qpos_nxt;
      pad_r   <= pad_nxt;
      count_r <= count_nxt;
      disc_r  <= disc_nxt;
    end
  end

  // while discarding, no partial quad is kept
  a_disc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (qpos_r == 2'd0 && pad_r == 2'd0 && count_r == '0))
    else $error("front holds stream state while discarding");

endmodule

`default_nettype wire

/* design/b64d_queue.sv */
// b64d_queue: short job queue between front and back end
// depends on b64d_pkg for the job type
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  b64d_pkg::job_t      wdata,
  output logic                full,
  input  wire logic           pop,
  output b64d_pkg::job_t      rdata,
  output logic                empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64d_pkg::job_t  slots_r [DEPTH];
  logic [AW-1:0]   wptr_r, wptr_nxt;
  logic [AW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job pushed into a full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

/* design/b64d_back.sv */
// b64d_back: turns queued jobs into results, one per out_pop cycle
// depends on b64d_pkg; reads jobs from b64d_queue
`timescale 1ns / 1ps
`default_nettype none

module b64d_back (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  b64d_pkg::job_t  q_rdata,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_data_byte,
  output logic            out_byte_valid,
  output logic [2:0]      out_status,
  output logic            out_run_last,
  output logic            out_stream_end
);

  b64d_pkg::job_t job_r, job_nxt;
  logic           cur_r, cur_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic           done;
  logic           advance;

  assign done    = (idx_r == job_r.nbytes - 2'd1);
  assign advance = !cur_r || (out_pop && done);
  assign q_pop   = advance && !q_empty;

  always_comb begin
    job_nxt = job_r;
    cur_nxt = cur_r;
    idx_nxt = idx_r;
    if (q_pop) begin
      job_nxt = q_rdata;
      cur_nxt = 1'b1;
      idx_nxt = 2'd0;
    end else if (advance) begin
      cur_nxt = 1'b0;
    end else if (out_pop) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_comb begin
    out_empty      = !cur_r;
    out_byte_valid = !job_r.is_err;
    out_status     = job_r.status;
    out_run_last   = done;
    out_stream_end = done && job_r.last;
    if (job_r.is_err) begin
      out_data_byte = 8'd0;
    end else begin
      case (idx_r)
        2'd0:    out_data_byte = job_r.group[23:16];
        2'd1:    out_data_byte = job_r.group[15:8];
        default: out_data_byte = job_r.group[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      cur_r <= cur_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r |-> (idx_r < job_r.nbytes && job_r.nbytes != 2'd0))
    else $error("result index beyond job length");

  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (!cur_r && !q_empty) |=> cur_r)
    else $error("waiting job not loaded into output stage");

endmodule

`default_nettype wire

/* design/base64_stream_decoder.sv */
// base64_stream_decoder: top level, streaming base64 decoder with error reporting
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
`timescale 1ns / 1ps
`default_nettype none

// channel     direction  transfer when            payload
// in_*        input      in_push && !in_full      in_code_char, in_stream_last
// out_*       output     out_pop && !out_empty    out_data_byte, out_byte_valid,
//                                                 out_status, out_run_last, out_stream_end
// cfg_*       input      cfg_valid && cfg_ready   cfg_max_length
//
// one character is taken per cycle while in_full is low; a completed quad or an error
// becomes one job in the queue, and the back end gives out one result per cycle from its
// output stage while out_pop is high; a job goes from a queue slot into the output stage
// register; in_full follows the job queue only, so a stalled output side backs up after
// QUEUE_DEPTH jobs plus the one in the output stage
// reset (synchronous, active low) clears stream state and the queue and loads
// max_length with 12 << 20; cfg_ready is always high

module base64_stream_decoder #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input characters
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [7:0]                     in_code_char,
  input  wire logic                           in_stream_last,
  // results
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [7:0]                          out_data_byte,
  output logic                                out_byte_valid,
  output logic [2:0]                          out_status,
  output logic                                out_run_last,
  output logic                                out_stream_end,
  // configuration
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [b64d_pkg::MAX_LEN_W-1:0] cfg_max_length
);

  logic [b64d_pkg::MAX_LEN_W-1:0] max_length_r, max_length_nxt;
  logic                           in_accept;
  logic                           job_push;
  b64d_pkg::job_t                 job_w;
  b64d_pkg::job_t                 q_rdata;
  logic                           q_full, q_empty, q_pop;

  // config register, to be written by the user only while the block is idle; not enforced here
  assign cfg_ready      = 1'b1;
  assign max_length_nxt = (cfg_valid && cfg_ready) ? cfg_max_length : max_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= b64d_pkg::MAX_LENGTH_RST;
    end else begin
      max_length_r <= max_length_nxt;
    end
  end

  // input transfer: queue space is reserved for every character
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  b64d_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_code_char   (in_code_char),
    .in_stream_last (in_stream_last),
    .max_length     (max_length_r),
    .job_push       (job_push),
    .job            (job_w)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_w),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  b64d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_rdata        (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_data_byte  (out_data_byte),
    .out_byte_valid (out_byte_valid),
    .out_status     (out_status),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end)
  );

endmodule

`default_nettype wire
